// ===== sv/timestamp_gated_event_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Timestamp-gated event queue assertion macros
// Shared concurrent assertion forms used by the queue's port checker.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_GATED_EVENT_QUEUE_ASSERT_SVH
`define TIMESTAMP_GATED_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define TGEQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define TGEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/tgeq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp-gated event queue package
// Event layout, request mode codes and result kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgeq_pkg;

	// One stored event, 64 bits, status byte in the top bits.
	typedef struct packed {
		logic [7:0]  status;
		logic [7:0]  data1;
		logic [7:0]  data2;
		logic [7:0]  channel;
		logic [31:0] tstamp;
	} ev_t;

	typedef logic [1:0] kind_t;

	localparam logic MODE_SCHED = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	localparam kind_t KIND_ACCEPT = 2'd0;
	localparam kind_t KIND_FULL   = 2'd1;
	localparam kind_t KIND_EVENT  = 2'd2;

endpackage

// ===== sv/timestamp_gated_event_queue.sv =====
// ----------------------------------------------------------------------------
// Timestamp-gated event queue
// Ring buffer of timestamped MIDI events, drained by time ticks.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_valid/in_ready channel. A schedule request
// (mode low) stores one event and always answers with exactly one result:
// accepted, or rejected when QUEUE_DEPTH-1 events are already held. A tick
// request (mode high) pops every head event whose timestamp is at or below
// now_time, one result per event, with last set on the final one. A tick
// with nothing ready, or with dispatch disabled, gives no result at all.
// Results leave on out_valid/out_ready through an output register, and
// every result carries the number of events still held.
// Sequence: a schedule is captured in ST_IDLE, then ST_SCHED does the memory
// write and gives the result. A tick is captured, then ST_TCHK pops head
// events back to back unless the receiver stalls, since the event memory is
// read ahead at the next read pointer. A tick that popped anything leaves
// ST_TCHK once the head is not ready, and ST_FLUSH sends the last event. A
// tick that pops nothing goes from ST_TCHK straight back to idle.
// Only one request is in work at a time; in_ready is high only when idle,
// but a new request is taken while an earlier result still waits.
// If the receiver stalls, the block holds the popped event and waits.
// Reset empties the queue and clears dispatch_enable; the event memory
// itself is not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_gated_event_queue
	import tgeq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// dispatch_enable register write
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  ev_status,
	input  logic [7:0]  ev_data1,
	input  logic [7:0]  ev_data2,
	input  logic [7:0]  ev_channel,
	input  logic [31:0] ev_time,
	input  logic [31:0] now_time,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  out_status,
	output logic [7:0]  out_data1,
	output logic [7:0]  out_data2,
	output logic [7:0]  out_channel,
	output logic [31:0] out_time,
	output logic [5:0]  pending,
	output logic        last
);

	// Pointer and count width; the count never exceeds QUEUE_DEPTH-1.
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCHED = 4'b0010,
		ST_TCHK  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	logic [PW-1:0] wr_ptr_q, rd_ptr_q, cnt_q;
	logic [PW-1:0] rd_addr;
	logic          dispatch_en_q;

	// Captured request.
	ev_t           item_ev_q;
	logic [31:0]   now_q;

	// Event memory with a registered read port.
	ev_t           mem [QUEUE_DEPTH];
	ev_t           rd_data_q;

	// Popped event that waits until we know whether it is the last one.
	logic          hold_valid_q;
	ev_t           hold_ev_q;
	logic [PW-1:0] hold_pend_q;

	// Output register.
	logic          out_valid_q;
	kind_t         out_kind_q;
	ev_t           out_ev_q;
	logic [PW-1:0] out_pend_q;
	logic          out_last_q;

	// Control decoded from the current state.
	logic          out_free;
	logic          full;
	logic          head_ready;
	logic          push, pop;
	logic          hold_load, hold_clr;
	logic          out_load;
	kind_t         out_kind_d;
	ev_t           out_ev_d;
	logic [PW-1:0] out_pend_d;
	logic          out_last_d;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_ready   = (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || out_ready;
	assign full       = (cnt_q == PW'(QUEUE_DEPTH - 1));
	// An empty queue never has a ready head, whatever stale data sits there.
	assign head_ready = (cnt_q != '0) && (rd_data_q.tstamp <= now_q);
	// Read ahead at the next pointer so the new head is ready right after a pop.
	assign rd_addr    = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;

	always_comb begin
		state_d    = state_q;
		push       = 1'b0;
		pop        = 1'b0;
		hold_load  = 1'b0;
		hold_clr   = 1'b0;
		out_load   = 1'b0;
		out_kind_d = KIND_ACCEPT;
		out_ev_d   = '0;
		out_pend_d = cnt_q;
		out_last_d = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_SCHED) begin
						state_d = ST_SCHED;
					end else if (dispatch_en_q) begin
						state_d = ST_TCHK;
					end
				end
			end
			ST_SCHED: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (full) begin
						out_kind_d = KIND_FULL;
					end else begin
						push       = 1'b1;
						out_pend_d = cnt_q + 1'b1;
					end
				end
			end
			ST_TCHK: begin
				if (head_ready) begin
					// A held event goes out with last low because another follows.
					if (!hold_valid_q || out_free) begin
						pop       = 1'b1;
						hold_load = 1'b1;
						if (hold_valid_q) begin
							out_load   = 1'b1;
							out_kind_d = KIND_EVENT;
							out_ev_d   = hold_ev_q;
							out_pend_d = hold_pend_q;
							out_last_d = 1'b0;
						end
					end
				end else if (hold_valid_q) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_d = KIND_EVENT;
					out_ev_d   = hold_ev_q;
					out_pend_d = hold_pend_q;
					hold_clr   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= item_ev_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			cnt_q         <= '0;
			dispatch_en_q <= 1'b0;
			hold_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				dispatch_en_q <= cfg_wdata;
			end
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
				cnt_q    <= cnt_q + 1'b1;
			end else if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
				cnt_q    <= cnt_q - 1'b1;
			end
			if (hold_load) begin
				hold_valid_q <= 1'b1;
			end else if (hold_clr) begin
				hold_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_ev_q <= '{status: ev_status, data1: ev_data1, data2: ev_data2,
				channel: ev_channel, tstamp: ev_time};
			now_q     <= now_time;
		end
		if (hold_load) begin
			hold_ev_q   <= rd_data_q;
			hold_pend_q <= cnt_q - 1'b1;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_ev_q   <= out_ev_d;
			out_pend_q <= out_pend_d;
			out_last_q <= out_last_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_kind_q;
	assign out_status  = out_ev_q.status;
	assign out_data1   = out_ev_q.data1;
	assign out_data2   = out_ev_q.data2;
	assign out_channel = out_ev_q.channel;
	assign out_time    = out_ev_q.tstamp;
	assign pending     = 6'(out_pend_q);
	assign last        = out_last_q;

endmodule

// ===== sv/tgeq_checker.sv =====
// ----------------------------------------------------------------------------
// Timestamp-gated event queue checker
// Port-level assertions on the result channel, bound to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "timestamp_gated_event_queue_assert.svh"

module tgeq_checker
	import tgeq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [7:0]  out_status,
	input logic [7:0]  out_data1,
	input logic [7:0]  out_data2,
	input logic [7:0]  out_channel,
	input logic [31:0] out_time,
	input logic [5:0]  pending,
	input logic        last
);

	// A stalled result holds.
	`TGEQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(pending) && $stable(last) && $stable(out_time), "stalled result changed")

	// Schedule answers carry no event and always close their request.
	`TGEQ_ASSERT_NOW(a_sched_shape, out_valid && kind != KIND_EVENT, last && out_status == 8'd0 && out_data1 == 8'd0 && out_data2 == 8'd0 && out_channel == 8'd0 && out_time == 32'd0, "schedule result malformed")

	// A rejection only happens with a full ring.
	`TGEQ_ASSERT_NOW(a_full_count, out_valid && kind == KIND_FULL, pending == 6'(QUEUE_DEPTH - 1), "rejected while not full")

	// A dispatched event that is not the last leaves another event behind.
	`TGEQ_ASSERT_NOW(a_more_pending, out_valid && kind == KIND_EVENT && !last, pending != 6'd0, "more events announced on an empty queue")

endmodule

bind timestamp_gated_event_queue tgeq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tgeq_checker (.*);

// ===== dv/tb_timestamp_gated_event_queue.sv =====
// ----------------------------------------------------------------------------
// Timestamp-gated event queue testbench
// Sends schedule and tick requests with random gaps and random result stalls.
// An internal ring model predicts every result. Each result is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_timestamp_gated_event_queue;
	import tgeq_pkg::*;

	localparam int DEPTH         = 64;
	localparam int RING_AW       = $clog2(DEPTH);
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 300000;

	// One request as it goes onto the input channel. Fields that the mode does
	// not use still carry random values, so every port bit gets toggled.
	typedef struct {
		logic        mode;
		ev_t         ev;
		logic [31:0] now;
	} request_t;

	// One result as the queue should present it.
	typedef struct {
		kind_t      kind;
		ev_t        ev;
		logic [5:0] held;
		logic       last;
	} queue_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [7:0]  ev_status;
	logic [7:0]  ev_data1;
	logic [7:0]  ev_data2;
	logic [7:0]  ev_channel;
	logic [31:0] ev_time;
	logic [31:0] now_time;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  out_status;
	logic [7:0]  out_data1;
	logic [7:0]  out_data2;
	logic [7:0]  out_channel;
	logic [31:0] out_time;
	logic [5:0]  pending;
	logic        last;

	// Requests waiting to be driven, and results waiting to arrive.
	request_t      queued_requests[$];
	queue_result_t expected_results[$];

	// Shadow of the queue: its event ring, pointers and the dispatch switch.
	ev_t ring_events[DEPTH];
	int  ring_wr;
	int  ring_rd;
	bit  dispatch_on;

	int pushed_n;
	int accepted_n;
	int mismatches;
	int cycle_count;
	bit quiet;

	timestamp_gated_event_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.ev_status  (ev_status),
		.ev_data1   (ev_data1),
		.ev_data2   (ev_data2),
		.ev_channel (ev_channel),
		.ev_time    (ev_time),
		.now_time   (now_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_status (out_status),
		.out_data1  (out_data1),
		.out_data2  (out_data2),
		.out_channel(out_channel),
		.out_time   (out_time),
		.pending    (pending),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Both sides draw a random wait per item, except during quiet
	// stretches, when they run back to back.
	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic ev_t rand_event(input logic [31:0] tstamp);
		ev_t e;
		e.status  = 8'($urandom_range(0, 255));
		e.data1   = 8'($urandom_range(0, 255));
		e.data2   = 8'($urandom_range(0, 255));
		e.channel = 8'($urandom_range(0, 255));
		e.tstamp  = tstamp;
		return e;
	endfunction

	function automatic int ring_held();
		return (ring_wr + DEPTH - ring_rd) % DEPTH;
	endfunction

	function automatic queue_result_t make_result(input kind_t k, input ev_t e);
		queue_result_t r;
		r.kind = k;
		r.ev   = e;
		r.held = 6'(ring_held());
		r.last = (k != KIND_EVENT);
		return r;
	endfunction

	task automatic push_sched(input ev_t e);
		request_t r;
		r.mode = MODE_SCHED;
		r.ev   = e;
		r.now  = $urandom;
		queued_requests.push_back(r);
		pushed_n++;
	endtask

	task automatic push_tick(input logic [31:0] now);
		request_t r;
		r.mode = MODE_TICK;
		r.ev   = rand_event($urandom);
		r.now  = now;
		queued_requests.push_back(r);
		pushed_n++;
	endtask

	// Works out what the queue answers to one accepted request and updates the
	// shadow ring. A schedule always gives one result; a tick with dispatch on
	// gives one result per ready head event and stops at the first one still in
	// the future. The compare is plain unsigned, with no wraparound handling.
	task automatic predict_request(input request_t r);
		queue_result_t res;
		int n;
		n = 0;
		accepted_n++;
		if (r.mode == MODE_SCHED) begin
			if ((ring_wr + 1) % DEPTH == ring_rd) begin
				expected_results.push_back(make_result(KIND_FULL, '0));
			end else begin
				ring_events[RING_AW'(ring_wr)] = r.ev;
				ring_wr = (ring_wr + 1) % DEPTH;
				expected_results.push_back(make_result(KIND_ACCEPT, '0));
			end
		end else if (dispatch_on) begin
			while (ring_rd != ring_wr && ring_events[RING_AW'(ring_rd)].tstamp <= r.now) begin
				res = make_result(KIND_EVENT, ring_events[RING_AW'(ring_rd)]);
				ring_rd = (ring_rd + 1) % DEPTH;
				res.held = 6'(ring_held());
				expected_results.push_back(res);
				n++;
			end
			if (n > 0) begin
				res = expected_results.pop_back();
				res.last = 1'b1;
				expected_results.push_back(res);
			end
		end
	endtask

	function automatic void compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Request driver. At each edge it notes an acceptance, then either holds
	// the current request, idles out its gap, or puts up the next request.
	// in_valid gets at most one assignment per edge, so a request that follows
	// with no gap simply keeps valid high.
	initial begin : request_driver
		request_t cur;
		int gap_left;
		gap_left   = 0;
		in_valid   = 1'b0;
		mode       = MODE_SCHED;
		ev_status  = '0;
		ev_data1   = '0;
		ev_data2   = '0;
		ev_channel = '0;
		ev_time    = '0;
		now_time   = '0;
		forever begin
			@(posedge clk);
			if (in_valid && in_ready) begin
				predict_request(cur);
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (queued_requests.size() > 0) begin
					cur = queued_requests.pop_front();
					mode       <= cur.mode;
					ev_status  <= cur.ev.status;
					ev_data1   <= cur.ev.data1;
					ev_data2   <= cur.ev.data2;
					ev_channel <= cur.ev.channel;
					ev_time    <= cur.ev.tstamp;
					now_time   <= cur.now;
					in_valid   <= 1'b1;
					gap_left = draw_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result checker. out_ready drops for a freshly drawn stall after every
	// accepted result, which can land stalls on any stage of a long drain.
	initial begin : result_checker
		queue_result_t want;
		int stall;
		stall     = draw_gap();
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d with no expectation waiting", kind);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					compare_field("kind", 32'(want.kind), 32'(kind));
					compare_field("out_status", 32'(want.ev.status), 32'(out_status));
					compare_field("out_data1", 32'(want.ev.data1), 32'(out_data1));
					compare_field("out_data2", 32'(want.ev.data2), 32'(out_data2));
					compare_field("out_channel", 32'(want.ev.channel), 32'(out_channel));
					compare_field("out_time", want.ev.tstamp, out_time);
					compare_field("pending", 32'(want.held), 32'(pending));
					compare_field("last", 32'(want.last), 32'(last));
				end
				stall = draw_gap();
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_timestamp_gated_event_queue failed");
		$finish;
	end

	// Waits until every request went in and every predicted result came out.
	// A tick that drains nothing leaves no trace in the result stream, so it
	// also waits out SETTLE_CYCLES to let the queue close out its last request.
	task automatic settle();
		do begin
			@(posedge clk);
		end while (accepted_n != pushed_n || expected_results.size() != 0 || !in_ready);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes happen only on a quiet queue.
	task automatic write_dispatch(input bit enable);
		settle();
		cfg_wdata <= enable;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		dispatch_on = enable;
	endtask

	// Dispatch is off after reset: ticks, even on an empty queue or with the
	// latest possible time, give nothing, while schedules are taken as usual.
	task automatic test_disabled_dispatch();
		write_dispatch(1'b0);
		push_tick(32'hFFFF_FFFF);
		push_sched('0);
		push_sched('1);
		push_tick(32'hFFFF_FFFF);
		push_tick(32'h0000_0000);
	endtask

	// Drains the all-zero and all-ones events from above with times at the
	// ends of the range, then ticks an empty queue.
	task automatic test_field_extremes();
		write_dispatch(1'b1);
		push_tick(32'h0000_0000);
		push_tick(32'hFFFF_FFFE);
		push_tick(32'hFFFF_FFFF);
		push_tick(32'hFFFF_FFFF);
	endtask

	// Head gating: an event in the upper half of the range must not count as
	// ready for a time just below it, and it blocks an earlier event behind it.
	// An event whose time equals the tick time is ready.
	task automatic test_time_gate();
		ev_t e;
		settle();
		push_sched(rand_event(32'h8000_0000));
		push_sched(rand_event(32'd5));
		push_tick(32'h7FFF_FFFF);
		push_tick(32'h8000_0000);
		e = '{status: 8'hA5, data1: 8'h5A, data2: 8'h0F, channel: 8'hF0, tstamp: 32'd100};
		push_sched(e);
		e = '{status: 8'h5A, data1: 8'hA5, data2: 8'hF0, channel: 8'h0F, tstamp: 32'd200};
		push_sched(e);
		push_sched(rand_event(32'd300));
		push_tick(32'd199);
		push_tick(32'd300);
	endtask

	// Fills the ring to its 63-event limit with dispatch off, checks that
	// further schedules are turned away, then drains everything in one tick.
	task automatic test_queue_full();
		write_dispatch(1'b0);
		for (int i = 0; i < DEPTH - 1; i++) begin
			push_sched(rand_event($urandom));
		end
		push_sched(rand_event($urandom));
		push_sched(rand_event($urandom));
		push_tick(32'hFFFF_FFFF);
		write_dispatch(1'b1);
		push_tick(32'hFFFF_FFFF);
	endtask

	// Random traffic in phases. Most requests follow a running timebase, so
	// schedules land a little ahead of it and ticks drain a few at a time. The
	// rest are noise with times anywhere in the range. Some phases run with
	// dispatch off, so the ring builds up for a long drain in the next phase,
	// and some run with no idling on either side.
	task automatic test_random_traffic();
		bit phase_dispatch[8] = '{1, 1, 0, 1, 1, 0, 1, 1};
		logic [31:0] base;
		int pick;
		for (int p = 0; p < 8; p++) begin
			write_dispatch(phase_dispatch[p]);
			quiet = (p == 3 || p == 6);
			case ($urandom_range(0, 2))
				0: base = 32'h0000_0000;
				1: base = 32'hFFFF_FF00;
				default: base = $urandom;
			endcase
			for (int i = 0; i < 36; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					push_sched(rand_event(base + $urandom_range(0, 200)));
				end else if (pick < 85) begin
					push_tick(base + $urandom_range(0, 250));
					base = base + $urandom_range(0, 60);
				end else if (pick < 93) begin
					push_sched(rand_event($urandom));
				end else begin
					push_tick($urandom);
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin : main_sequence
		pushed_n    = 0;
		accepted_n  = 0;
		mismatches  = 0;
		quiet       = 1'b0;
		ring_wr     = 0;
		ring_rd     = 0;
		dispatch_on = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled_dispatch();
		test_field_extremes();
		test_time_gate();
		test_queue_full();
		test_random_traffic();
		settle();
		if (mismatches == 0) begin
			$display("tb_timestamp_gated_event_queue passed");
		end else begin
			$display("tb_timestamp_gated_event_queue failed");
		end
		$finish;
	end

endmodule
